>>> hw/rtl/modexp_pkg.sv
`timescale 1ns / 1ps

package modexp_pkg;

	// Default width of the base, exponent, modulus and result words.
	localparam int unsigned WORD_BITS_DEF = 63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MSTART,
		ST_MWAIT,
		ST_OUT
	} modexp_state_t;

endpackage

>>> hw/rtl/modexp_reduce.sv
`timescale 1ns / 1ps

module modexp_reduce #(
	parameter int unsigned WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] value,
	input  logic [WORD_BITS-1:0] m,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);
	localparam int unsigned CW = $clog2(WORD_BITS);
	localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] val_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS-1:0] rem_next;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// Restoring reduction, one bit of the value per cycle from the top.
	// The partial remainder stays below m, so the shifted value stays below 2m.
	always_comb begin
		trial = {rem_q, val_q[WORD_BITS-1]};
		if (trial >= {1'b0, m}) begin
			trial = trial - {1'b0, m};
		end
		rem_next = trial[WORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[WORD_BITS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done   = done_q;
	assign result = rem_q;

endmodule

>>> hw/rtl/modexp_mulmod.sv
`timescale 1ns / 1ps

module modexp_mulmod #(
	parameter int unsigned WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0] m,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);
	localparam int unsigned CW = $clog2(WORD_BITS);
	localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] acc_next;
	logic [WORD_BITS-1:0] x_next;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// Both operands are below m, so a single conditional subtract reduces the sum.
	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b,
		input logic [WORD_BITS-1:0] mm
	);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, mm}) begin
			s = s - {1'b0, mm};
		end
		return s[WORD_BITS-1:0];
	endfunction

	// The multiplier is scanned from its low bit; the multiplicand doubles
	// modulo m each cycle, in parallel with the conditional accumulate.
	always_comb begin
		acc_next = y_q[0] ? add_mod(acc_q, x_q, m) : acc_q;
		x_next   = add_mod(x_q, x_q, m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= x_next;
			y_q   <= {1'b0, y_q[WORD_BITS-1:1]};
			acc_q <= acc_next;
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

>>> hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// Modular exponentiation: power_mod = base ** exponent mod the modulus register.
// The input word (base, exponent) is taken on in_valid and in_ready; the result
// word is offered on out_valid and power_mod until out_ready takes it.
// The user must write the modulus through cfg_we and cfg_data only while the
// block is idle; the block itself does not enforce this. One word is worked on
// at a time. After acceptance the base is first reduced bit-serially. Then for
// each exponent bit, from the lowest up to the highest set bit, two serial
// modular multipliers, one squaring the base and one multiplying the
// accumulator, run in lockstep and handle one multiplier bit per cycle.
// The block is ready for the next word in the same cycle that out_valid rises.
// A zero exponent or a zero modulus finishes right after the reduction or at once.
// The finished result sits in an output register, so a new word is accepted
// while an earlier result still waits; when the receiver stalls and the output
// register is full, the next result is held until the register frees up.
// Reset sets the modulus to all ones and leaves the block idle and empty.
module modular_exponentiation #(
	parameter int unsigned WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WORD_BITS-1:0] base,
	input  logic [WORD_BITS-1:0] exponent,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] power_mod,
	input  logic                 cfg_we,
	input  logic [WORD_BITS-1:0] cfg_data
);
	import modexp_pkg::*;

	modexp_state_t state_q, state_next;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] power_mod_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 mod_zero;
	logic                 mod_one;
	logic                 exp_last;
	logic                 red_start;
	logic                 red_done;
	logic [WORD_BITS-1:0] red_result;
	logic                 mul_start;
	logic                 sq_done;
	logic [WORD_BITS-1:0] sq_result;
	logic                 mul_done;
	logic [WORD_BITS-1:0] mul_result;
	logic                 out_load;

	assign accept   = in_valid && in_ready;
	assign mod_zero = (modulus_q == '0);
	assign mod_one  = (modulus_q == WORD_BITS'(1));
	// True when no set bit remains above the one now being processed.
	assign exp_last = (exp_q[WORD_BITS-1:1] == '0);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = mod_zero ? ST_OUT : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_done) begin
					state_next = (exp_q == '0) ? ST_OUT : ST_MSTART;
				end
			end
			ST_MSTART: state_next = ST_MWAIT;
			ST_MWAIT: begin
				if (sq_done) begin
					state_next = exp_last ? ST_OUT : ST_MSTART;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		red_start = (state_q == ST_IDLE) && in_valid && !mod_zero;
		mul_start = (state_q == ST_MSTART);
		out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				modulus_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= exponent;
			acc_q <= (mod_zero || mod_one) ? '0 : WORD_BITS'(1);
		end
		if (state_q == ST_REDUCE && red_done) begin
			base_q <= red_result;
		end
		if (state_q == ST_MWAIT && sq_done) begin
			base_q <= sq_result;
			if (exp_q[0]) begin
				acc_q <= mul_result;
			end
			exp_q <= {1'b0, exp_q[WORD_BITS-1:1]};
		end
		if (out_load) begin
			power_mod_q <= acc_q;
		end
	end

	modexp_reduce #(.WORD_BITS(WORD_BITS)) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.value  (base),
		.m      (modulus_q),
		.done   (red_done),
		.result (red_result)
	);

	modexp_mulmod #(.WORD_BITS(WORD_BITS)) u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (base_q),
		.y      (base_q),
		.m      (modulus_q),
		.done   (sq_done),
		.result (sq_result)
	);

	modexp_mulmod #(.WORD_BITS(WORD_BITS)) u_multiply (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (acc_q),
		.y      (base_q),
		.m      (modulus_q),
		.done   (mul_done),
		.result (mul_result)
	);

	assign out_valid = out_valid_q;
	assign power_mod = power_mod_q;

	// The two multipliers are started together and must finish together.
	assert property (@(posedge clk) disable iff (!arst_n) sq_done == mul_done)
		else $error("square and multiply units out of step");

	// Operands handed to the multipliers must already be reduced.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MSTART) |-> (acc_q < modulus_q) && (base_q < modulus_q))
		else $error("multiplier operand not reduced");

	// A new result only appears when the sequencer hands one over.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result presented without a finished word");

	// The multipliers run only for words with a nonzero modulus.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mod_zero)
		else $error("multiply started with a zero modulus");

endmodule
